/* hdl/tlla_pkg.sv */
// ----------------------------------------------------------------------------
// tlla_pkg
// Shared constants and types for the toroidal life-like automaton step core.
// ----------------------------------------------------------------------------
package tlla_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIM_W    = 7;
  localparam int MASK_W   = 9;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_BIRTH    = 2'd2,
    REG_SURVIVAL = 2'd3
  } reg_idx_t;

  typedef logic [MAX_COLS-1:0] row_t;

endpackage

/* hdl/toroidal_life_like_automaton_step_core.sv */
// ----------------------------------------------------------------------------
// toroidal_life_like_automaton_step_core
// Cell grid held as one row per memory word; cell writes read-modify-write
// a row, cell reads read one, a generation sweeps the rows through a three-row window.
// ----------------------------------------------------------------------------
// Path: a cell read or write is held in the s1 stage and then the output register.
// Throughput: cell reads and writes at one beat per cycle while the output is not
// stalled; a generation holds off input until its sweep is done, one memory row
// read and written per cycle through the single read port of the grid memory.
// Reset: synchronous, active low; registers return to their reset values and
// the row valid bits clear, so the whole grid reads dead at once.
module toroidal_life_like_automaton_step_core
  import tlla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // cmd[1:0], row[7:2], col[13:8], alive_in[14]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // alive_out[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  typedef enum logic {ST_IDLE, ST_GEN} state_t;

  state_t             st_r;
  logic [DIM_W-1:0]   grid_width_r, grid_height_r;
  logic [MASK_W-1:0]  birth_mask_r, survival_mask_r;

  row_t               grid_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid_r;
  row_t               rd_q_r;
  logic               rd_vq_r;

  logic               s1_v_r, s1_val_r, s1_in_r;
  cmd_t               s1_cmd_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [COL_W-1:0]   s1_col_r;

  logic               out_v_r, out_bit_r;

  logic               fwd_v_r;
  logic [ROW_W-1:0]   fwd_row_r;
  row_t               fwd_data_r;

  logic [DIM_W-1:0]   gj_r, gdj_r;
  logic               gdv_r;
  row_t               win_prev_r, win_cur_r, save0_r;

  logic [DIM_W-1:0]   h_eff, w_eff, h_m1, gj_m1, gdj_m2;
  cmd_t               in_cmd;
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic               in_val, in_inside, accept, out_free, s1_adv;
  row_t               rdata, s1_data, s1_wrow, gen_new, gen_wrow;
  logic               rd_en, wr_en;
  logic [ROW_W-1:0]   rd_addr, wr_addr;
  row_t               wr_data;
  logic               gen_issue, gen_write;

  function automatic row_t next_row(input row_t prv, input row_t cur, input row_t nxt,
                                    input logic [DIM_W-1:0] w,
                                    input logic [MASK_W-1:0] bm,
                                    input logic [MASK_W-1:0] sm);
    row_t             res;
    logic [COL_W-1:0] li, ri, wm1;
    logic [3:0]       cnt;
    wm1 = COL_W'(w - 1'b1);
    for (int c = 0; c < MAX_COLS; c++) begin
      li  = (c == 0) ? wm1 : COL_W'(c - 1);
      ri  = ((c + 1) == int'(w)) ? '0 : COL_W'(c + 1);
      cnt = 4'(prv[li]) + 4'(prv[c]) + 4'(prv[ri]) + 4'(cur[li]) + 4'(cur[ri])
          + 4'(nxt[li]) + 4'(nxt[c]) + 4'(nxt[ri]);
      res[c] = (c < int'(w)) ? (cur[c] ? sm[cnt] : bm[cnt]) : cur[c];
    end
    return res;
  endfunction

  always_comb begin
    if (grid_height_r == '0)                     h_eff = DIM_W'(1);
    else if (grid_height_r > DIM_W'(MAX_ROWS))   h_eff = DIM_W'(MAX_ROWS);
    else                                         h_eff = grid_height_r;
    if (grid_width_r == '0)                      w_eff = DIM_W'(1);
    else if (grid_width_r > DIM_W'(MAX_COLS))    w_eff = DIM_W'(MAX_COLS);
    else                                         w_eff = grid_width_r;
  end

  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_row    = in_tdata[7:2];
  assign in_col    = in_tdata[13:8];
  assign in_val    = in_tdata[14];
  assign in_inside = ({1'b0, in_row} < h_eff) && ({1'b0, in_col} < w_eff);

  assign out_free  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && out_free;
  assign in_tready = (st_r == ST_IDLE) && (!s1_v_r || (out_free && s1_cmd_r != CMD_STEP));
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W-1){1'b0}}, out_bit_r};

  assign rdata   = rd_vq_r ? rd_q_r : '0;
  assign s1_data = (fwd_v_r && fwd_row_r == s1_row_r) ? fwd_data_r : rdata;

  always_comb begin
    s1_wrow = s1_data;
    s1_wrow[s1_col_r] = s1_val_r;
  end

  assign h_m1      = h_eff - 1'b1;
  assign gj_m1     = gj_r - 1'b1;
  assign gdj_m2    = gdj_r - DIM_W'(2);
  assign gen_issue = (st_r == ST_GEN) && (gj_r <= h_eff);
  assign gen_new   = (gdj_r == h_eff + 1'b1) ? save0_r : rdata;
  assign gen_write = (st_r == ST_GEN) && gdv_r && (gdj_r >= DIM_W'(2));
  assign gen_wrow  = next_row(win_prev_r, win_cur_r, gen_new, w_eff,
                              birth_mask_r, survival_mask_r);

  always_comb begin
    rd_en   = accept || gen_issue;
    rd_addr = gen_issue ? ((gj_r == '0) ? h_m1[ROW_W-1:0] : gj_m1[ROW_W-1:0]) : in_row;
    if (gen_write) begin
      wr_en   = 1'b1;
      wr_addr = gdj_m2[ROW_W-1:0];
      wr_data = gen_wrow;
    end else begin
      wr_en   = s1_adv && (s1_cmd_r == CMD_WRITE) && s1_in_r;
      wr_addr = s1_row_r;
      wr_data = s1_wrow;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= ST_IDLE;
      grid_width_r    <= DIM_W'(64);
      grid_height_r   <= DIM_W'(64);
      birth_mask_r    <= MASK_W'(8);
      survival_mask_r <= MASK_W'(12);
      row_valid_r     <= '0;
      rd_vq_r         <= 1'b0;
      s1_v_r          <= 1'b0;
      out_v_r         <= 1'b0;
      out_bit_r       <= 1'b0;
      fwd_v_r         <= 1'b0;
      gj_r            <= '0;
      gdj_r           <= '0;
      gdv_r           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_WIDTH:    grid_width_r    <= cfg_data[DIM_W-1:0];
          REG_HEIGHT:   grid_height_r   <= cfg_data[DIM_W-1:0];
          REG_BIRTH:    birth_mask_r    <= cfg_data;
          REG_SURVIVAL: survival_mask_r <= cfg_data;
          default: ;
        endcase
      end

      if (rd_en) begin
        rd_vq_r <= row_valid_r[rd_addr];
      end
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
        fwd_v_r    <= 1'b1;
        fwd_row_r  <= wr_addr;
        fwd_data_r <= wr_data;
      end

      if (out_free) begin
        out_v_r   <= s1_adv;
        out_bit_r <= (s1_cmd_r == CMD_READ) && s1_in_r && s1_data[s1_col_r];
      end

      if (accept) begin
        s1_v_r   <= 1'b1;
        s1_cmd_r <= in_cmd;
        s1_row_r <= in_row;
        s1_col_r <= in_col;
        s1_val_r <= in_val;
        s1_in_r  <= in_inside;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      unique case (st_r)
        ST_IDLE: begin
          if (s1_adv && s1_cmd_r == CMD_STEP) begin
            st_r  <= ST_GEN;
            gj_r  <= '0;
            gdv_r <= 1'b0;
          end
        end
        ST_GEN: begin
          gdv_r <= (gj_r <= h_eff + 1'b1);
          gdj_r <= gj_r;
          if (gj_r <= h_eff + 1'b1) begin
            gj_r <= gj_r + 1'b1;
          end
          if (gdv_r) begin
            win_prev_r <= win_cur_r;
            win_cur_r  <= gen_new;
            if (gdj_r == DIM_W'(1)) begin
              save0_r <= rdata;
            end
            if (gdj_r == h_eff + 1'b1) begin
              st_r <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tlla_chk.sv */
// ----------------------------------------------------------------------------
// tlla_chk
// Port-level checks for the toroidal life-like automaton step core.
// ----------------------------------------------------------------------------
module tlla_chk
  import tlla_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [IN_W-1:0]      in_tdata,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_W-1:0]     out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:1] == '0)
    else $error("output padding not zero");

  a_step_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == CMD_STEP |=> !in_tready)
    else $error("input taken during generation");

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready |=> out_tvalid)
    else $error("accepted beat gave no result");

endmodule

bind toroidal_life_like_automaton_step_core tlla_chk u_tlla_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
